/* src/scsi_cdb_to_ata_fis_translator_macros.svh */
// Assertion macros shared by the translator's checker.
`ifndef SCSI_CDB_TO_ATA_FIS_TRANSLATOR_MACROS_SVH
`define SCSI_CDB_TO_ATA_FIS_TRANSLATOR_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define SAT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, ignored while rst is high.
`define SAT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

/* src/sat_pkg.sv */
// Types and constants of the SCSI CDB to ATA FIS translator.
package sat_pkg;

   // Result status codes.
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_DISPATCH = 3'd1;
   localparam logic [2:0] ST_INVALID  = 3'd2;
   localparam logic [2:0] ST_LENERR   = 3'd3;
   localparam logic [2:0] ST_NOTAVAIL = 3'd4;
   localparam logic [2:0] ST_SCSIERR  = 3'd5;

   // SCSI opcodes.
   localparam logic [7:0] OP_TEST_UNIT_READY = 8'h00;
   localparam logic [7:0] OP_REQUEST_SENSE   = 8'h03;
   localparam logic [7:0] OP_READ6           = 8'h08;
   localparam logic [7:0] OP_WRITE6          = 8'h0A;
   localparam logic [7:0] OP_INQUIRY         = 8'h12;
   localparam logic [7:0] OP_START_STOP      = 8'h1B;
   localparam logic [7:0] OP_PREVENT_ALLOW   = 8'h1E;
   localparam logic [7:0] OP_READ_CAP10      = 8'h25;
   localparam logic [7:0] OP_READ10          = 8'h28;
   localparam logic [7:0] OP_WRITE10         = 8'h2A;
   localparam logic [7:0] OP_SYNC_CACHE      = 8'h35;
   localparam logic [7:0] OP_PASS_THRU16     = 8'h85;
   localparam logic [7:0] OP_READ16          = 8'h88;
   localparam logic [7:0] OP_WRITE16         = 8'h8A;
   localparam logic [7:0] OP_READ_CAP16      = 8'h9E;
   localparam logic [7:0] OP_PASS_THRU12     = 8'hA1;
   localparam logic [7:0] OP_READ12          = 8'hA8;
   localparam logic [7:0] OP_WRITE12         = 8'hAA;

   // Service action expected in byte 1 of READ CAPACITY 16.
   localparam logic [7:0] SA_READ_CAP16 = 8'h10;

   // ATA command opcodes.
   localparam logic [7:0] ATA_READ_DMA        = 8'hC8;
   localparam logic [7:0] ATA_WRITE_DMA       = 8'hCA;
   localparam logic [7:0] ATA_READ_DMA_EXT    = 8'h25;
   localparam logic [7:0] ATA_WRITE_DMA_EXT   = 8'h35;
   localparam logic [7:0] ATA_READ_FPDMA      = 8'h60;
   localparam logic [7:0] ATA_WRITE_FPDMA     = 8'h61;
   localparam logic [7:0] ATA_FLUSH_CACHE     = 8'hE7;

   localparam logic [7:0] ATA_DEV_LBA = 8'h40;

   // Length limits and ranges.
   localparam logic [31:0] INQUIRY_MIN_LEN = 32'd36;
   localparam logic [31:0] RCAP16_MIN_LEN  = 32'd32;
   localparam logic [31:0] RCAP10_MIN_LEN  = 32'd8;
   localparam logic [32:0] COUNT_SIX_ZERO  = 33'h100;
   localparam logic [32:0] COUNT_LBA28_MAX = 33'h100;
   localparam logic [32:0] COUNT_MAX       = 33'h10000;
   localparam logic [63:0] RCAP10_CLAMP    = 64'h0000_0000_FFFF_FFFF;

   // Configuration register indexes (paddr[4:3]).
   localparam logic [1:0] REG_CAPACITY  = 2'd0;
   localparam logic [1:0] REG_NCQ_DEPTH = 2'd1;
   localparam logic [1:0] REG_HOST_NCQ  = 2'd2;

   typedef struct packed {
      logic [63:0] cdb_low;
      logic [63:0] cdb_high;
      logic [31:0] buffer_len;
      logic        polled;
      logic [4:0]  slot_tag;
   } sat_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  ata_command;
      logic        is_write;
      logic        use_ncq;
      logic        poll_mode;
      logic [47:0] lba_sent;
      logic [7:0]  device_byte;
      logic [7:0]  count_low;
      logic [7:0]  count_high;
      logic [7:0]  features_low;
      logic [7:0]  features_high;
      logic [63:0] last_lba;
   } sat_rsp_type;

   typedef struct packed {
      logic [47:0] capacity_sectors;
      logic [5:0]  ncq_depth;
      logic        host_supports_ncq;
   } sat_cfg_type;

endpackage

/* src/sat_csr.sv */
// Configuration registers of the translator behind an APB-style port.
module sat_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [4:0]           paddr,
   input  logic [63:0]          pwdata,
   output logic [63:0]          prdata,
   output logic                 pready,
   output sat_pkg::sat_cfg_type cfg
);
   import sat_pkg::*;

   logic [47:0] capacity_ff, capacity_in;
   logic [5:0]  depth_ff, depth_in;
   logic        host_ncq_ff, host_ncq_in;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & pready;
   assign reg_idx = paddr[4:3];

   always_comb begin
      capacity_in = capacity_ff;
      depth_in    = depth_ff;
      host_ncq_in = host_ncq_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_CAPACITY:  capacity_in = pwdata[47:0];
            REG_NCQ_DEPTH: depth_in    = pwdata[5:0];
            REG_HOST_NCQ:  host_ncq_in = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= '0;
         depth_ff    <= 6'd1;
         host_ncq_ff <= 1'b0;
      end else begin
         capacity_ff <= capacity_in;
         depth_ff    <= depth_in;
         host_ncq_ff <= host_ncq_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_CAPACITY:  prdata = {16'd0, capacity_ff};
         REG_NCQ_DEPTH: prdata = {58'd0, depth_ff};
         REG_HOST_NCQ:  prdata = {63'd0, host_ncq_ff};
         default:       prdata = '0;
      endcase
   end

   assign cfg.capacity_sectors  = capacity_ff;
   assign cfg.ncq_depth         = depth_ff;
   assign cfg.host_supports_ncq = host_ncq_ff;

endmodule

/* src/sat_xlate.sv */
// Combinational decode of one CDB into a FIS or a completion status.
module sat_xlate (
   input  sat_pkg::sat_req_type req,
   input  sat_pkg::sat_cfg_type cfg,
   output sat_pkg::sat_rsp_type rsp
);
   import sat_pkg::*;

   logic [7:0]   b [16];
   logic [127:0] cdb;
   logic [7:0]   op;
   logic         rw;
   logic         six;
   logic         wr;
   logic         ncq_ok;
   logic [63:0]  lba;
   logic [32:0]  count;
   logic [63:0]  last_raw;

   assign cdb = {req.cdb_high, req.cdb_low};
   assign op  = b[0];
   assign wr  = op[1];

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         b[i] = cdb[8*i +: 8];
      end
   end

   assign ncq_ok   = (cfg.ncq_depth > 6'd1) && cfg.host_supports_ncq && !req.polled;
   assign last_raw = {16'd0, cfg.capacity_sectors} - 64'd1;

   // Field extraction for the read and write forms.
   always_comb begin
      rw    = 1'b1;
      six   = 1'b0;
      lba   = '0;
      count = '0;
      unique case (op) inside
         OP_READ6, OP_WRITE6: begin
            six   = 1'b1;
            lba   = {43'd0, b[1][4:0], b[2], b[3]};
            count = (b[4] == 8'd0) ? COUNT_SIX_ZERO : {25'd0, b[4]};
         end
         OP_READ10, OP_WRITE10: begin
            lba   = {32'd0, b[2], b[3], b[4], b[5]};
            count = {17'd0, b[7], b[8]};
         end
         OP_READ12, OP_WRITE12: begin
            lba   = {32'd0, b[2], b[3], b[4], b[5]};
            count = {1'b0, b[6], b[7], b[8], b[9]};
         end
         OP_READ16, OP_WRITE16: begin
            lba   = {b[2], b[3], b[4], b[5], b[6], b[7], b[8], b[9]};
            count = {1'b0, b[10], b[11], b[12], b[13]};
         end
         default: rw = 1'b0;
      endcase
   end

   always_comb begin
      rsp        = '0;
      rsp.status = ST_INVALID;
      if (rw) begin
         if (!six && count == 33'd0) begin
            // A zero-length transfer has nothing to move.
            rsp.status = ST_OK;
         end else if (count > COUNT_MAX || lba[63:48] != 16'd0) begin
            rsp.status = ST_INVALID;
         end else begin
            rsp.status      = ST_DISPATCH;
            rsp.is_write    = wr;
            rsp.poll_mode   = req.polled;
            rsp.device_byte = ATA_DEV_LBA;
            if (ncq_ok) begin
               rsp.ata_command   = wr ? ATA_WRITE_FPDMA : ATA_READ_FPDMA;
               rsp.use_ncq       = 1'b1;
               rsp.lba_sent      = lba[47:0];
               rsp.count_low     = {req.slot_tag, 3'b000};
               rsp.features_low  = count[7:0];
               rsp.features_high = count[15:8];
            end else if (count > COUNT_LBA28_MAX || lba[47:28] != 20'd0) begin
               rsp.ata_command = wr ? ATA_WRITE_DMA_EXT : ATA_READ_DMA_EXT;
               rsp.lba_sent    = lba[47:0];
               rsp.count_low   = count[7:0];
               rsp.count_high  = count[15:8];
            end else begin
               // A count of 256 wraps to 0 in the 8-bit field.
               rsp.ata_command = wr ? ATA_WRITE_DMA : ATA_READ_DMA;
               rsp.lba_sent    = {24'd0, lba[23:0]};
               rsp.device_byte = ATA_DEV_LBA | {4'd0, lba[27:24]};
               rsp.count_low   = count[7:0];
            end
         end
      end else begin
         unique case (op) inside
            OP_TEST_UNIT_READY, OP_START_STOP, OP_PREVENT_ALLOW:
               rsp.status = ST_OK;
            OP_REQUEST_SENSE:
               rsp.status = ST_SCSIERR;
            OP_INQUIRY: begin
               if (b[1][0])
                  rsp.status = ST_NOTAVAIL;
               else if (req.buffer_len < INQUIRY_MIN_LEN)
                  rsp.status = ST_LENERR;
               else
                  rsp.status = ST_OK;
            end
            OP_PASS_THRU16, OP_PASS_THRU12:
               rsp.status = ST_NOTAVAIL;
            OP_SYNC_CACHE: begin
               rsp.status      = ST_DISPATCH;
               rsp.ata_command = ATA_FLUSH_CACHE;
            end
            OP_READ_CAP16: begin
               if (b[1] != SA_READ_CAP16) begin
                  rsp.status = ST_INVALID;
               end else if (req.buffer_len < RCAP16_MIN_LEN) begin
                  rsp.status = ST_LENERR;
               end else begin
                  rsp.status   = ST_OK;
                  rsp.last_lba = last_raw;
               end
            end
            OP_READ_CAP10: begin
               if (req.buffer_len < RCAP10_MIN_LEN) begin
                  rsp.status = ST_LENERR;
               end else begin
                  rsp.status   = ST_OK;
                  rsp.last_lba = (last_raw[63:32] != 32'd0) ? RCAP10_CLAMP : last_raw;
               end
            end
            default: rsp.status = ST_INVALID;
         endcase
      end
   end

endmodule

/* src/scsi_cdb_to_ata_fis_translator.sv */
// Top level of the SCSI CDB to ATA host-to-device FIS translator.
//
// The translator takes one SCSI disk CDB per transfer on the req_ channel and
// returns exactly one result per CDB on the rsp_ channel, in order. Each
// CDB passes an input register, one stage of decode logic and a result
// register. A result is offered on rsp_valid once its request has passed
// the input register and the result register. While rsp_ready stays
// high, a new request can be taken in every cycle: one transfer per cycle
// sustained.
// The result register decouples the two sides: while a finished result waits
// for rsp_ready, the input register still takes the next CDB, and only when
// both registers hold work does req_ready drop. Reads and writes of 6, 10,
// 12 and 16 bytes become a DMA FIS in NCQ (FPDMA), LBA48 or LBA28 form;
// SYNCHRONIZE CACHE becomes FLUSH CACHE; READ CAPACITY reports the last LBA
// from capacity_sectors; the remaining opcodes complete with a status only.
// FIS fields are zero unless the status is dispatch, and last_lba is zero
// unless a READ CAPACITY completes successfully. The registers capacity_sectors
// (byte address 0), ncq_depth (address 8) and host_supports_ncq (address 16)
// sit behind a 64-bit APB-style port. The user must write them only while the
// block holds no request in flight; the block itself does not enforce it.
module scsi_cdb_to_ata_fis_translator (
   input  logic                 clock,
   input  logic                 reset,
   // Request channel.
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sat_pkg::sat_req_type req_payload,
   // Result channel.
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sat_pkg::sat_rsp_type rsp_payload,
   // Configuration port.
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [4:0]           paddr,
   input  logic [63:0]          pwdata,
   output logic [63:0]          prdata,
   output logic                 pready
);
   import sat_pkg::*;

   sat_cfg_type cfg;

   // Input register stage.
   logic        in_valid_ff, in_valid_in;
   sat_req_type in_data_ff, in_data_in;

   // Result register stage.
   logic        out_valid_ff, out_valid_in;
   sat_rsp_type out_data_ff, out_data_in;

   sat_rsp_type xlate_rsp;
   logic        req_xfer;
   logic        advance;

   sat_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sat_xlate u_xlate (
      .req (in_data_ff),
      .cfg (cfg),
      .rsp (xlate_rsp)
   );

   // The decoded item moves on whenever the result register is empty or
   // its result is being transferred out in this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_xfer) begin
         in_valid_in = 1'b1;
         in_data_in  = req_payload;
      end
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_data_in  = xlate_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule

/* src/sat_checker.sv */
// Port-level assertions for the translator and their bind to the top level.
`include "scsi_cdb_to_ata_fis_translator_macros.svh"

module sat_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input sat_pkg::sat_rsp_type rsp_payload
);
   import sat_pkg::*;

   logic rsp_stall;
   logic rsp_no_fis;
   logic rsp_not_ok;
   logic fis_clear;
   logic ncq_cmd_ok;

   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign rsp_no_fis = rsp_valid && (rsp_payload.status != ST_DISPATCH);
   assign rsp_not_ok = rsp_valid && (rsp_payload.status != ST_OK);
   assign fis_clear  = (rsp_payload.ata_command == 8'd0) && (rsp_payload.lba_sent == 48'd0) &&
                       !rsp_payload.use_ncq && (rsp_payload.device_byte == 8'd0);
   assign ncq_cmd_ok = ((rsp_payload.ata_command == ATA_READ_FPDMA) ||
                        (rsp_payload.ata_command == ATA_WRITE_FPDMA)) && !rsp_payload.poll_mode;

   // A stalled result keeps its value until it is transferred.
   `SAT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

   // After reset no result is pending and a request can be taken.
   `SAT_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && req_ready)

   // FIS fields are only filled for a dispatch.
   `SAT_ASSERT_IMPL(a_fis_zero, clock, reset, rsp_no_fis, fis_clear)

   // The last LBA is only reported with a successful completion.
   `SAT_ASSERT_IMPL(a_last_lba_zero, clock, reset, rsp_not_ok, rsp_payload.last_lba == 64'd0)

   // A queued FIS always carries an FPDMA command and is never polled.
   `SAT_ASSERT_IMPL(a_ncq_cmd, clock, reset, rsp_valid && rsp_payload.use_ncq, ncq_cmd_ok)

endmodule

bind scsi_cdb_to_ata_fis_translator sat_checker u_sat_checker (.*);

/* dv/sat_fis_checker.sv */
// Checker that predicts and compares every result of the CDB to FIS translator.
`timescale 1ns / 100ps

module sat_fis_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  sat_pkg::sat_req_type req_payload,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  sat_pkg::sat_rsp_type rsp_payload,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [4:0]           paddr,
   input  logic [63:0]          pwdata,
   input  logic                 pready,
   output int                   fail_count,
   output int                   pending
);
   import sat_pkg::*;

   sat_cfg_type dev_cfg;
   sat_rsp_type fis_expect_q[$];

   // Big-endian field of n bytes starting at CDB byte 'at'.
   function automatic logic [63:0] cdb_field(logic [127:0] cdb, int at, int n);
      logic [63:0] v;
      v = '0;
      for (int k = 0; k < n; k++) v = (v << 8) | cdb[8*(at+k) +: 8];
      return v;
   endfunction

   function automatic sat_rsp_type translate_cdb(sat_req_type rq);
      logic [127:0] cdb;
      logic [7:0]   opc;
      logic [63:0]  lba;
      logic [63:0]  cnt;
      logic [63:0]  last;
      logic         is_rw;
      logic         six;
      logic         wr;
      sat_rsp_type  fis;
      cdb    = {rq.cdb_high, rq.cdb_low};
      opc    = cdb[7:0];
      fis    = '0;
      fis.status = ST_INVALID;
      is_rw  = 1'b1;
      six    = 1'b0;
      lba    = '0;
      cnt    = '0;
      case (opc)
         OP_READ6, OP_WRITE6: begin
            six = 1'b1;
            lba = cdb_field(cdb, 1, 3) & 64'h1F_FFFF;
            cnt = cdb_field(cdb, 4, 1);
            if (cnt == 0) cnt = 64'(COUNT_SIX_ZERO);
         end
         OP_READ10, OP_WRITE10: begin
            lba = cdb_field(cdb, 2, 4);
            cnt = cdb_field(cdb, 7, 2);
         end
         OP_READ12, OP_WRITE12: begin
            lba = cdb_field(cdb, 2, 4);
            cnt = cdb_field(cdb, 6, 4);
         end
         OP_READ16, OP_WRITE16: begin
            lba = cdb_field(cdb, 2, 8);
            cnt = cdb_field(cdb, 10, 4);
         end
         default: is_rw = 1'b0;
      endcase

      if (is_rw) begin
         wr = opc[1];
         if (!six && cnt == 0) begin
            fis.status = ST_OK;
         end else if (cnt > 64'(COUNT_MAX) || lba > 64'hFFFF_FFFF_FFFF) begin
            fis.status = ST_INVALID;
         end else begin
            fis.status      = ST_DISPATCH;
            fis.is_write    = wr;
            fis.poll_mode   = rq.polled;
            fis.device_byte = ATA_DEV_LBA;
            if (dev_cfg.ncq_depth > 6'd1 && dev_cfg.host_supports_ncq && !rq.polled) begin
               fis.ata_command   = wr ? ATA_WRITE_FPDMA : ATA_READ_FPDMA;
               fis.use_ncq       = 1'b1;
               fis.lba_sent      = lba[47:0];
               fis.count_low     = {rq.slot_tag, 3'b000};
               fis.features_low  = cnt[7:0];
               fis.features_high = cnt[15:8];
            end else if (cnt > 64'(COUNT_LBA28_MAX) || lba > 64'h0FFF_FFFF) begin
               fis.ata_command = wr ? ATA_WRITE_DMA_EXT : ATA_READ_DMA_EXT;
               fis.lba_sent    = lba[47:0];
               fis.count_low   = cnt[7:0];
               fis.count_high  = cnt[15:8];
            end else begin
               fis.ata_command = wr ? ATA_WRITE_DMA : ATA_READ_DMA;
               fis.lba_sent    = {24'd0, lba[23:0]};
               fis.device_byte = ATA_DEV_LBA | {4'd0, lba[27:24]};
               fis.count_low   = cnt[7:0];
            end
         end
      end else begin
         case (opc)
            OP_TEST_UNIT_READY, OP_START_STOP, OP_PREVENT_ALLOW: fis.status = ST_OK;
            OP_REQUEST_SENSE: fis.status = ST_SCSIERR;
            OP_INQUIRY: begin
               if (cdb[8])
                  fis.status = ST_NOTAVAIL;
               else
                  fis.status = (rq.buffer_len < INQUIRY_MIN_LEN) ? ST_LENERR : ST_OK;
            end
            OP_PASS_THRU16, OP_PASS_THRU12: fis.status = ST_NOTAVAIL;
            OP_SYNC_CACHE: begin
               fis.status      = ST_DISPATCH;
               fis.ata_command = ATA_FLUSH_CACHE;
            end
            OP_READ_CAP16, OP_READ_CAP10: begin
               if (opc == OP_READ_CAP16 && cdb[15:8] != SA_READ_CAP16) begin
                  fis.status = ST_INVALID;
               end else if (rq.buffer_len < ((opc == OP_READ_CAP16) ? RCAP16_MIN_LEN
                                                                     : RCAP10_MIN_LEN)) begin
                  fis.status = ST_LENERR;
               end else begin
                  // A zero capacity wraps to all ones.
                  last = {16'd0, dev_cfg.capacity_sectors} - 64'd1;
                  if (opc == OP_READ_CAP10 && last > RCAP10_CLAMP) last = RCAP10_CLAMP;
                  fis.last_lba = last;
                  fis.status   = ST_OK;
               end
            end
            default: fis.status = ST_INVALID;
         endcase
      end
      return fis;
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   task automatic compare_fis(sat_rsp_type want, sat_rsp_type got);
      check_field("status", 64'(want.status), 64'(got.status));
      check_field("ata_command", 64'(want.ata_command), 64'(got.ata_command));
      check_field("is_write", 64'(want.is_write), 64'(got.is_write));
      check_field("use_ncq", 64'(want.use_ncq), 64'(got.use_ncq));
      check_field("poll_mode", 64'(want.poll_mode), 64'(got.poll_mode));
      check_field("lba_sent", 64'(want.lba_sent), 64'(got.lba_sent));
      check_field("device_byte", 64'(want.device_byte), 64'(got.device_byte));
      check_field("count_low", 64'(want.count_low), 64'(got.count_low));
      check_field("count_high", 64'(want.count_high), 64'(got.count_high));
      check_field("features_low", 64'(want.features_low), 64'(got.features_low));
      check_field("features_high", 64'(want.features_high), 64'(got.features_high));
      check_field("last_lba", want.last_lba, got.last_lba);
   endtask

   always @(posedge clock) begin
      sat_rsp_type oldest;
      if (reset) begin
         dev_cfg.capacity_sectors  <= '0;
         dev_cfg.ncq_depth         <= 6'd1;
         dev_cfg.host_supports_ncq <= 1'b0;
         fis_expect_q.delete();
         fail_count = 0;
         pending <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:3])
               REG_CAPACITY:  dev_cfg.capacity_sectors  <= pwdata[47:0];
               REG_NCQ_DEPTH: dev_cfg.ncq_depth         <= pwdata[5:0];
               REG_HOST_NCQ:  dev_cfg.host_supports_ncq <= pwdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) fis_expect_q.push_back(translate_cdb(req_payload));
         if (rsp_valid && rsp_ready) begin
            if (fis_expect_q.size() == 0) begin
               $error("result transfer with no command outstanding");
               fail_count++;
            end else begin
               oldest = fis_expect_q.pop_front();
               compare_fis(oldest, rsp_payload);
            end
         end
         pending <= fis_expect_q.size();
      end
   end

endmodule

/* dv/tb.sv */
// Top of the translator testbench: clock, reset, stimulus and the verdict.
`timescale 1ns / 100ps

module tb;
   import sat_pkg::*;

   localparam int RESET_CYCLES    = 8;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int PHASE_COUNT     = 8;
   localparam int ITEMS_PER_PHASE = 240;
   // The result is offered after the input and result registers; a little margin.
   localparam int SETTLE_CYCLES   = 4;

   // Receiver stall patterns.
   typedef enum int {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   sat_req_type req_payload;
   logic        rsp_valid;
   logic        rsp_ready;
   sat_rsp_type rsp_payload;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [4:0]  paddr;
   logic [63:0] pwdata;
   logic [63:0] prdata;
   logic        pready;

   int          fail_count;
   int          pending;
   int unsigned cycle_count = 0;
   int unsigned burst_left  = 0;

   scsi_cdb_to_ata_fis_translator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   // The checker sits beside the block, watching both channels and the
   // register port; it reports how many results are still outstanding and
   // how many checks failed.
   sat_fis_checker i_fis_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .pready      (pready),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A run that hangs, for instance because a result never arrives, ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // The receiver changes its stall pattern at random: no stall
   // at all, a coin toss, mostly stalled, or a fixed two-of-three rhythm.
   initial begin
      stall_mode_type mode;
      int unsigned    hold;
      rsp_ready <= 1'b0;
      mode = STALL_NONE;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold == 0) begin
            mode = stall_mode_type'($urandom_range(0, 3));
            hold = $urandom_range(5, 60);
         end
         hold--;
         case (mode)
            STALL_NONE:  rsp_ready <= 1'b1;
            STALL_COIN:  rsp_ready <= ($urandom_range(0, 1) == 1);
            STALL_HEAVY: rsp_ready <= ($urandom_range(0, 7) == 0);
            default:     rsp_ready <= (hold % 3 != 0);
         endcase
      end
   end

   function automatic logic [127:0] random_bytes();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   function automatic sat_req_type make_req(logic [127:0] cdb, logic [31:0] blen,
                                            logic pol, logic [4:0] tag);
      sat_req_type rq;
      rq.cdb_low    = cdb[63:0];
      rq.cdb_high   = cdb[127:64];
      rq.buffer_len = blen;
      rq.polled     = pol;
      rq.slot_tag   = tag;
      return rq;
   endfunction

   // Non-transfer command: opcode and byte 1 over arbitrary filler bytes.
   function automatic logic [127:0] cmd_cdb(logic [7:0] op, logic [7:0] b1,
                                            logic [127:0] fill);
      logic [127:0] cdb;
      cdb        = fill;
      cdb[7:0]   = op;
      cdb[15:8]  = b1;
      return cdb;
   endfunction

   // Read or write CDB: the LBA and the count go in big-endian at the offsets
   // of the opcode's form; the other bytes keep the filler.
   function automatic logic [127:0] rw_cdb(logic [7:0] op, logic [63:0] lba,
                                           logic [31:0] cnt, logic [127:0] fill);
      logic [127:0] cdb;
      int           lba_at;
      int           lba_n;
      int           cnt_at;
      int           cnt_n;
      cdb      = fill;
      cdb[7:0] = op;
      case (op)
         OP_READ6, OP_WRITE6: begin
            lba_at = 1; lba_n = 3; cnt_at = 4; cnt_n = 1;
         end
         OP_READ10, OP_WRITE10: begin
            lba_at = 2; lba_n = 4; cnt_at = 7; cnt_n = 2;
         end
         OP_READ12, OP_WRITE12: begin
            lba_at = 2; lba_n = 4; cnt_at = 6; cnt_n = 4;
         end
         default: begin
            lba_at = 2; lba_n = 8; cnt_at = 10; cnt_n = 4;
         end
      endcase
      for (int k = 0; k < lba_n; k++) cdb[8*(lba_at+k) +: 8] = lba[8*(lba_n-1-k) +: 8];
      for (int k = 0; k < cnt_n; k++) cdb[8*(cnt_at+k) +: 8] = cnt[8*(cnt_n-1-k) +: 8];
      return cdb;
   endfunction

   // Random command. Most are reads and writes with LBAs and counts that sit
   // on the mode boundaries (28-bit LBA, 256 sectors, 48-bit LBA, 65536
   // sectors); the rest are the other known opcodes and random noise.
   function automatic sat_req_type random_req();
      logic [127:0] fill;
      logic [7:0]   op;
      logic [7:0]   b1;
      logic [63:0]  lba;
      logic [31:0]  cnt;
      logic [31:0]  blen;
      int unsigned  pick;
      fill = random_bytes();
      case ($urandom_range(0, 3))
         0:       blen = $urandom_range(0, 40);
         1:       blen = $urandom_range(0, 64);
         2:       blen = 32'hFFFF_FFFF;
         default: blen = $urandom;
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         case ($urandom_range(0, 7))
            0:       op = OP_READ6;
            1:       op = OP_WRITE6;
            2:       op = OP_READ10;
            3:       op = OP_WRITE10;
            4:       op = OP_READ12;
            5:       op = OP_WRITE12;
            6:       op = OP_READ16;
            default: op = OP_WRITE16;
         endcase
         case ($urandom_range(0, 9))
            0, 1:    lba = 64'($urandom_range(0, 65535));
            2, 3:    lba = 64'h0FFF_FFF0 + $urandom_range(0, 31);
            4, 5:    lba = {32'd0, $urandom};
            6, 7:    lba = {$urandom, $urandom} & 64'h0000_FFFF_FFFF_FFFF;
            8:       lba = 64'h0000_FFFF_FFFF_FFFE + $urandom_range(0, 3);
            default: lba = {$urandom, $urandom};
         endcase
         case ($urandom_range(0, 9))
            0:       cnt = 32'd0;
            1:       cnt = 32'd1;
            2, 3:    cnt = $urandom_range(1, 256);
            4:       cnt = $urandom_range(254, 259);
            5, 6:    cnt = $urandom_range(1, 65535);
            7:       cnt = $urandom_range(65534, 65538);
            default: cnt = $urandom;
         endcase
         fill = rw_cdb(op, lba, cnt, fill);
      end else if (pick < 95) begin
         b1 = fill[15:8];
         case ($urandom_range(0, 9))
            0:       op = OP_TEST_UNIT_READY;
            1:       op = OP_REQUEST_SENSE;
            2:       op = OP_INQUIRY;
            3:       op = OP_START_STOP;
            4:       op = OP_PREVENT_ALLOW;
            5:       op = OP_READ_CAP10;
            6: begin
               op = OP_READ_CAP16;
               if ($urandom_range(0, 9) != 0) b1 = SA_READ_CAP16;
            end
            7:       op = OP_SYNC_CACHE;
            8:       op = OP_PASS_THRU16;
            default: op = OP_PASS_THRU12;
         endcase
         fill = cmd_cdb(op, b1, fill);
      end else begin
         // Noise: any opcode at all, mostly ones the block does not know.
         op   = 8'($urandom);
         fill = cmd_cdb(op, fill[15:8], fill);
      end
      return make_req(fill, blen, ($urandom_range(0, 3) == 0), 5'($urandom));
   endfunction

   // Offer one command and hold it until the transfer. The sender works in
   // bursts; at the end of a burst it may idle, and some bursts are long
   // stretches with no idling at all.
   task automatic send_item(sat_req_type rq);
      int unsigned gap;
      req_valid   <= 1'b1;
      req_payload <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap == 0) burst_left += $urandom_range(20, 80);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stop sending and wait for every outstanding result, then wait out
   // SETTLE_CYCLES so the pipeline is empty. The pending count is registered
   // behind the handshake, hence the clock edge waited before it is first read.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write: setup cycle, access cycle, then an idle cycle so that
   // back-to-back writes never lower and raise psel in the same step.
   task automatic write_reg(logic [1:0] idx, logic [63:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Device settings per phase: the extremes first, then random ones.
   task automatic set_phase(int phase);
      logic [47:0] cap;
      logic [5:0]  depth;
      logic        host;
      case (phase)
         0: begin cap = 48'hFFFF_FFFF_FFFF; depth = 6'd32; host = 1'b1; end
         1: begin cap = 48'd1;              depth = 6'd2;  host = 1'b1; end
         2: begin cap = 48'h1_0000_0000;    depth = 6'd1;  host = 1'b1; end
         3: begin cap = 48'd0;              depth = 6'd32; host = 1'b0; end
         default: begin
            case ($urandom_range(0, 2))
               0:       cap = 48'($urandom_range(0, 65535));
               1:       cap = 48'h0_FFFF_FFFE + $urandom_range(0, 3);
               default: cap = 48'({$urandom, $urandom});
            endcase
            depth = 6'($urandom_range(1, 32));
            host  = 1'($urandom_range(0, 1));
         end
      endcase
      write_reg(REG_CAPACITY, {16'd0, cap});
      write_reg(REG_NCQ_DEPTH, {58'd0, depth});
      write_reg(REG_HOST_NCQ, {63'd0, host});
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      psel        <= 1'b0;
      penable     <= 1'b0;
      pwrite      <= 1'b0;
      paddr       <= '0;
      pwdata      <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed commands under the reset settings (no capacity, no NCQ):
      // all-zero and all-one descriptors, every status path, READ CAPACITY
      // with a zero capacity and the 32-bit clamp, the six-byte form with a
      // zero count and masked LBA, zero-length transfers, the LBA28/LBA48
      // boundaries and both out-of-range cases.
      send_item(make_req('0, 32'd0, 1'b0, 5'd0));
      send_item(make_req({128{1'b1}}, 32'hFFFF_FFFF, 1'b1, 5'd31));
      send_item(make_req(cmd_cdb(OP_START_STOP, 8'h00, random_bytes()), 32'd0, 1'b0, 5'd1));
      send_item(make_req(cmd_cdb(OP_PREVENT_ALLOW, 8'h00, random_bytes()), 32'd9, 1'b1, 5'd2));
      send_item(make_req(cmd_cdb(OP_REQUEST_SENSE, 8'h00, random_bytes()), 32'd18, 1'b0, 5'd3));
      send_item(make_req(cmd_cdb(OP_INQUIRY, 8'h01, random_bytes()), 32'd100, 1'b0, 5'd4));
      send_item(make_req(cmd_cdb(OP_INQUIRY, 8'hFE, random_bytes()), 32'd35, 1'b0, 5'd5));
      send_item(make_req(cmd_cdb(OP_INQUIRY, 8'h00, random_bytes()), 32'd36, 1'b0, 5'd6));
      send_item(make_req(cmd_cdb(OP_PASS_THRU16, 8'h00, random_bytes()), 32'd512, 1'b0, 5'd7));
      send_item(make_req(cmd_cdb(OP_PASS_THRU12, 8'h00, random_bytes()), 32'd512, 1'b1, 5'd8));
      send_item(make_req(cmd_cdb(OP_SYNC_CACHE, 8'hFF, random_bytes()), 32'd0, 1'b1, 5'd9));
      send_item(make_req(cmd_cdb(OP_READ_CAP16, 8'h11, random_bytes()), 32'd100, 1'b0, 5'd10));
      send_item(make_req(cmd_cdb(OP_READ_CAP16, SA_READ_CAP16, random_bytes()), 32'd31,
                         1'b0, 5'd11));
      send_item(make_req(cmd_cdb(OP_READ_CAP16, SA_READ_CAP16, random_bytes()), 32'd32,
                         1'b0, 5'd12));
      send_item(make_req(cmd_cdb(OP_READ_CAP10, 8'h00, random_bytes()), 32'd7, 1'b0, 5'd13));
      send_item(make_req(cmd_cdb(OP_READ_CAP10, 8'h00, random_bytes()), 32'hFFFF_FFFF,
                         1'b0, 5'd14));
      send_item(make_req(rw_cdb(OP_READ6, 64'hFF_FFFF, 32'd0, {128{1'b1}}), 32'd0,
                         1'b0, 5'd15));
      send_item(make_req(rw_cdb(OP_WRITE6, 64'd0, 32'd1, '0), 32'd0, 1'b1, 5'd16));
      send_item(make_req(rw_cdb(OP_READ10, 64'd77, 32'd0, random_bytes()), 32'd0,
                         1'b0, 5'd17));
      send_item(make_req(rw_cdb(OP_WRITE10, 64'h0FFF_FFFF, 32'd256, random_bytes()),
                         32'd0, 1'b0, 5'd18));
      send_item(make_req(rw_cdb(OP_READ10, 64'h1000_0000, 32'd1, random_bytes()),
                         32'd0, 1'b1, 5'd19));
      send_item(make_req(rw_cdb(OP_READ12, 64'd5, 32'd257, random_bytes()), 32'd0,
                         1'b0, 5'd20));
      send_item(make_req(rw_cdb(OP_WRITE12, 64'd5, 32'h1_0001, random_bytes()), 32'd0,
                         1'b0, 5'd21));
      send_item(make_req(rw_cdb(OP_READ16, 64'h1_0000_0000_0000, 32'd1, random_bytes()),
                         32'd0, 1'b0, 5'd22));
      send_item(make_req(rw_cdb(OP_WRITE16, 64'h0000_FFFF_FFFF_FFFF, 32'h1_0000,
                                random_bytes()), 32'd0, 1'b0, 5'd23));

      // Random phases. Each one drains the block completely, so the sender
      // pauses until every result is back, then loads new device settings
      // while nothing is in flight.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_drained();
         set_phase(phase);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) send_item(random_req());
      end

      wait_drained();
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+src
src/sat_pkg.sv
src/sat_csr.sv
src/sat_xlate.sv
src/scsi_cdb_to_ata_fis_translator.sv
src/sat_checker.sv
dv/sat_fis_checker.sv
dv/tb.sv
